// ----- rtl/core/integer_matrix_multiply_core_assert.svh -----
// assertion helpers for the matrix multiply core
`ifndef INTEGER_MATRIX_MULTIPLY_CORE_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_CORE_ASSERT_SVH

// same-cycle implication, masked while reset is asserted
`define IMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, masked while reset is asserted
`define IMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/imm_pkg.sv -----
`default_nettype none

package imm_pkg;

	// matrix geometry
	localparam int MAX_ROWS  = 64;
	localparam int MAX_INNER = 64;
	localparam int MAX_COLS  = 64;

	// field widths
	localparam int KIND_W  = 2;
	localparam int ROW_W   = 6;
	localparam int COL_W   = 6;
	localparam int ELEM_W  = 16;
	localparam int PROD_W  = 2 * ELEM_W;
	localparam int ACC_W   = 38;
	localparam int DIM_W   = 7;

	// storage and counter widths
	localparam int INNER_AW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
	localparam int LEFT_AW  = (MAX_ROWS * MAX_INNER > 1) ? $clog2(MAX_ROWS * MAX_INNER) : 1;
	localparam int RIGHT_AW = (MAX_INNER * MAX_COLS > 1) ? $clog2(MAX_INNER * MAX_COLS) : 1;
	localparam int LEN_W    = $clog2(MAX_INNER + 1);

	// configuration port
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] REG_INNER_DIM = PADDR_W'(0);
	localparam logic [DIM_W-1:0]   INNER_DIM_RST = DIM_W'(64);

	// request kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE_LEFT  = 2'd0,
		KIND_WRITE_RIGHT = 2'd1,
		KIND_COMPUTE     = 2'd2
	} kind_t;

endpackage

`default_nettype wire

// ----- rtl/core/imm_if.sv -----
`default_nettype none

// request channel: element writes and compute requests
interface imm_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [imm_pkg::KIND_W-1:0]        kind;
	logic [imm_pkg::ROW_W-1:0]         row_index;
	logic [imm_pkg::COL_W-1:0]         col_index;
	logic signed [imm_pkg::ELEM_W-1:0] element_value;

	modport source (output valid, kind, row_index, col_index, element_value, input ready);
	modport sink   (input valid, kind, row_index, col_index, element_value, output ready);
endinterface

// result channel: one product element per compute request
interface imm_res_if;
	logic                             valid;
	logic                             ready;
	logic [imm_pkg::ROW_W-1:0]        out_row;
	logic [imm_pkg::COL_W-1:0]        out_col;
	logic signed [imm_pkg::ACC_W-1:0] product_value;

	modport source (output valid, out_row, out_col, product_value, input ready);
	modport sink   (input valid, out_row, out_col, product_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/integer_matrix_multiply_core.sv -----
// Integer matrix multiply core.
// cmd channel (valid/ready): kind 0 writes one left-matrix element, kind 1 one
// right-matrix element, kind 2 requests the dot product of left row row_index
// and right column col_index over inner_dim positions; kind 3 is dropped.
// res channel (valid/ready): one result per compute with out_row, out_col and
// the 38-bit signed sum.
// Element writes are taken while the core is idle and never produce a result.
// A compute holds cmd.ready low until its sum is handed over: the loop issues
// one read per cycle from each element memory (one read port each) into a
// single multiply-accumulate; the read, product and accumulator registers
// then drain before the sum moves to the output register and onto res.
// A zero inner_dim skips the loop and hands over a zero sum.
// inner_dim is clamped to 64 for the loop length.
// The result sits in an output register; further writes and computes are
// accepted while it waits. If the receiver stalls, a finished compute waits
// in the core until the output register frees up.
// APB register 0 (address 0) holds inner_dim, reset value 64.
// Reset clears control state and sets inner_dim to 64; element memories are
// not cleared and must be written before they are used by a compute.
`default_nettype none

`include "integer_matrix_multiply_core_assert.svh"

module integer_matrix_multiply_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	imm_cmd_if.sink                              cmd,
	imm_res_if.source                            res,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [imm_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [imm_pkg::PDATA_W-1:0]     pwdata,
	output logic      [imm_pkg::PDATA_W-1:0]     prdata,
	output logic                                 pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                              state_q;
	logic [imm_pkg::DIM_W-1:0]           inner_dim_q;
	logic [imm_pkg::ROW_W-1:0]           row_q;
	logic [imm_pkg::COL_W-1:0]           col_q;
	logic [imm_pkg::LEN_W-1:0]           len_q;
	logic [imm_pkg::LEN_W-1:0]           k_q;
	logic signed [imm_pkg::ACC_W-1:0]    acc_q;

	logic                                vld_s1;
	logic                                last_s1;
	logic                                vld_s2;
	logic                                last_s2;
	logic signed [imm_pkg::ELEM_W-1:0]   left_rdata_s1;
	logic signed [imm_pkg::ELEM_W-1:0]   right_rdata_s1;
	logic signed [imm_pkg::PROD_W-1:0]   prod_s2;

	logic                                res_valid_q;
	logic [imm_pkg::ROW_W-1:0]           res_row_q;
	logic [imm_pkg::COL_W-1:0]           res_col_q;
	logic signed [imm_pkg::ACC_W-1:0]    res_value_q;

	logic signed [imm_pkg::ELEM_W-1:0]   left_mem  [imm_pkg::MAX_ROWS * imm_pkg::MAX_INNER];
	logic signed [imm_pkg::ELEM_W-1:0]   right_mem [imm_pkg::MAX_INNER * imm_pkg::MAX_COLS];

	logic                                cmd_fire;
	logic                                is_left_wr;
	logic                                is_right_wr;
	logic                                is_compute;
	logic                                left_we;
	logic                                right_we;
	logic [imm_pkg::LEFT_AW-1:0]         left_waddr;
	logic [imm_pkg::RIGHT_AW-1:0]        right_waddr;
	logic                                issue;
	logic                                issue_last;
	logic [imm_pkg::INNER_AW-1:0]        k_idx;
	logic [imm_pkg::LEFT_AW-1:0]         left_raddr;
	logic [imm_pkg::RIGHT_AW-1:0]        right_raddr;
	logic [imm_pkg::LEN_W-1:0]           eff_len;
	logic                                cmp_in_range;
	logic                                res_free;
	logic                                res_load;
	logic                                cfg_wr;

	// request decode
	assign cmd.ready   = (state_q == ST_IDLE);
	assign cmd_fire    = cmd.valid && cmd.ready;
	assign is_left_wr  = (cmd.kind == imm_pkg::KIND_WRITE_LEFT);
	assign is_right_wr = (cmd.kind == imm_pkg::KIND_WRITE_RIGHT);
	assign is_compute  = (cmd.kind == imm_pkg::KIND_COMPUTE);

	// element writes, dropped when outside the target matrix
	assign left_we  = cmd_fire && is_left_wr
		&& (32'(cmd.row_index) < 32'(imm_pkg::MAX_ROWS))
		&& (32'(cmd.col_index) < 32'(imm_pkg::MAX_INNER));
	assign right_we = cmd_fire && is_right_wr
		&& (32'(cmd.row_index) < 32'(imm_pkg::MAX_INNER))
		&& (32'(cmd.col_index) < 32'(imm_pkg::MAX_COLS));
	assign left_waddr  = imm_pkg::LEFT_AW'(cmd.row_index) * imm_pkg::LEFT_AW'(imm_pkg::MAX_INNER)
		+ imm_pkg::LEFT_AW'(cmd.col_index);
	assign right_waddr = imm_pkg::RIGHT_AW'(cmd.row_index) * imm_pkg::RIGHT_AW'(imm_pkg::MAX_COLS)
		+ imm_pkg::RIGHT_AW'(cmd.col_index);

	// compute setup: clamped length and range check
	assign eff_len = (32'(inner_dim_q) > 32'(imm_pkg::MAX_INNER))
		? imm_pkg::LEN_W'(imm_pkg::MAX_INNER) : imm_pkg::LEN_W'(inner_dim_q);
	assign cmp_in_range = (32'(cmd.row_index) < 32'(imm_pkg::MAX_ROWS))
		&& (32'(cmd.col_index) < 32'(imm_pkg::MAX_COLS));

	// inner loop read addresses
	assign issue       = (state_q == ST_RUN);
	assign issue_last  = issue && (k_q == len_q - imm_pkg::LEN_W'(1));
	assign k_idx       = k_q[imm_pkg::INNER_AW-1:0];
	assign left_raddr  = imm_pkg::LEFT_AW'(row_q) * imm_pkg::LEFT_AW'(imm_pkg::MAX_INNER)
		+ imm_pkg::LEFT_AW'(k_idx);
	assign right_raddr = imm_pkg::RIGHT_AW'(k_idx) * imm_pkg::RIGHT_AW'(imm_pkg::MAX_COLS)
		+ imm_pkg::RIGHT_AW'(col_q);

	// left element memory
	always_ff @(posedge clk) begin
		if (left_we) begin
			left_mem[left_waddr] <= cmd.element_value;
		end
		if (issue) begin
			left_rdata_s1 <= left_mem[left_raddr];
		end
	end

	// right element memory
	always_ff @(posedge clk) begin
		if (right_we) begin
			right_mem[right_waddr] <= cmd.element_value;
		end
		if (issue) begin
			right_rdata_s1 <= right_mem[right_raddr];
		end
	end

	// multiplier stage
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prod_s2 <= left_rdata_s1 * right_rdata_s1;
		end
	end

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == imm_pkg::REG_INNER_DIM);
	assign prdata = (paddr == imm_pkg::REG_INNER_DIM)
		? imm_pkg::PDATA_W'(inner_dim_q) : '0;

	// result channel
	assign res_free          = !res_valid_q || res.ready;
	assign res_load          = (state_q == ST_DONE) && res_free;
	assign res.valid         = res_valid_q;
	assign res.out_row       = res_row_q;
	assign res.out_col       = res_col_q;
	assign res.product_value = res_value_q;

	// sequencer, accumulator and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			inner_dim_q <= imm_pkg::INNER_DIM_RST;
			row_q       <= '0;
			col_q       <= '0;
			len_q       <= '0;
			k_q         <= '0;
			acc_q       <= '0;
			vld_s1      <= 1'b0;
			last_s1     <= 1'b0;
			vld_s2      <= 1'b0;
			last_s2     <= 1'b0;
			res_valid_q <= 1'b0;
			res_row_q   <= '0;
			res_col_q   <= '0;
			res_value_q <= '0;
		end else begin
			if (cfg_wr) begin
				inner_dim_q <= pwdata[imm_pkg::DIM_W-1:0];
			end

			vld_s1  <= issue;
			last_s1 <= issue_last;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;

			if (vld_s2) begin
				acc_q <= acc_q + imm_pkg::ACC_W'(prod_s2);
			end

			// output register: load a finished sum or release a taken one
			if (res_load) begin
				res_valid_q <= 1'b1;
				res_row_q   <= row_q;
				res_col_q   <= col_q;
				res_value_q <= acc_q;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_fire && is_compute) begin
						row_q <= cmd.row_index;
						col_q <= cmd.col_index;
						len_q <= eff_len;
						k_q   <= '0;
						acc_q <= '0;
						if (cmp_in_range && (eff_len != '0)) begin
							state_q <= ST_RUN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_RUN: begin
					k_q <= k_q + imm_pkg::LEN_W'(1);
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (vld_s2 && last_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	`IMM_ASSERT_NOW(a_idle_pipe_empty, clk, arst_n, state_q == ST_IDLE, !vld_s1 && !vld_s2, "pipeline busy while idle")
	`IMM_ASSERT_NOW(a_issue_in_bounds, clk, arst_n, state_q == ST_RUN, k_q < len_q, "inner index past length")
	`IMM_ASSERT_NEXT(a_drain_to_done, clk, arst_n, state_q == ST_DRAIN && !(vld_s2 && last_s2), state_q == ST_DRAIN, "left drain early")
	`IMM_ASSERT_NOW(a_result_from_done, clk, arst_n, $rose(res_valid_q), $past(state_q) == ST_DONE, "result without finished compute")

endmodule

`default_nettype wire

// ----- tb/imm_tb_pkg.sv -----
`timescale 1ns / 1ps

package imm_tb_pkg;
	import imm_pkg::*;

	// request kind that the core drops
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

	typedef struct {
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic signed [ACC_W-1:0] sum;
	} product_t;

	class product_scoreboard;
		logic signed [ELEM_W-1:0] left_mat [MAX_ROWS*MAX_INNER];
		logic signed [ELEM_W-1:0] right_mat [MAX_INNER*MAX_COLS];
		logic [DIM_W-1:0]         inner_dim;
		product_t                 pending_products [$];
		int                       errors;

		function new();
			inner_dim = INNER_DIM_RST;
			errors    = 0;
			foreach (left_mat[i]) left_mat[i] = '0;
			foreach (right_mat[i]) right_mat[i] = '0;
		endfunction

		function void set_inner_dim(logic [DIM_W-1:0] d);
			inner_dim = d;
		endfunction

		function int pending();
			return pending_products.size();
		endfunction

		// dot product of a left row and a right column, kept modulo 2^ACC_W
		function logic signed [ACC_W-1:0] dot_product(logic [ROW_W-1:0] row,
				logic [COL_W-1:0] col);
			longint acc;
			int     len;
			acc = 0;
			len = (inner_dim > MAX_INNER) ? MAX_INNER : int'(inner_dim);
			if (row < MAX_ROWS && col < MAX_COLS) begin
				for (int k = 0; k < len; k++)
					acc += longint'(left_mat[row*MAX_INNER + k]) *
						longint'(right_mat[k*MAX_COLS + col]);
			end
			return ACC_W'(acc);
		endfunction

		// accepted request: update the stores or queue a product
		function void note_request(logic [KIND_W-1:0] kind, logic [ROW_W-1:0] row,
				logic [COL_W-1:0] col, logic signed [ELEM_W-1:0] val);
			product_t p;
			case (kind)
				KIND_WRITE_LEFT: begin
					if (row < MAX_ROWS && col < MAX_INNER)
						left_mat[row*MAX_INNER + col] = val;
				end
				KIND_WRITE_RIGHT: begin
					if (row < MAX_INNER && col < MAX_COLS)
						right_mat[row*MAX_COLS + col] = val;
				end
				KIND_COMPUTE: begin
					p.row = row;
					p.col = col;
					p.sum = dot_product(row, col);
					pending_products.push_back(p);
				end
				default: ;
			endcase
		endfunction

		// compare one result against the oldest queued product
		function void check_product(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
				logic signed [ACC_W-1:0] sum);
			product_t want;
			if (pending_products.size() == 0) begin
				$error("result row %0d col %0d with no pending compute", row, col);
				errors++;
				return;
			end
			want = pending_products.pop_front();
			if (row !== want.row) begin
				$error("out_row: expected %0d, actual %0d", want.row, row);
				errors++;
			end
			if (col !== want.col) begin
				$error("out_col: expected %0d, actual %0d", want.col, col);
				errors++;
			end
			if (sum !== want.sum) begin
				$error("product_value: expected %0d, actual %0d", want.sum, sum);
				errors++;
			end
		endfunction
	endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import imm_pkg::*;
	import imm_tb_pkg::*;

	localparam int ITEM_TARGET  = 2000;
	localparam int QUIET_FROM   = 1700;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 800;
	localparam int CYCLE_LIMIT  = 1000000;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	imm_cmd_if cmd ();
	imm_res_if res ();

	integer_matrix_multiply_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	product_scoreboard sb;

	// elements written so far, so that no compute reads an unwritten one
	bit left_set [MAX_ROWS*MAX_INNER];
	bit right_set [MAX_INNER*MAX_COLS];
	int cur_len     = MAX_INNER;
	int items_sent  = 0;
	bit quiet       = 1'b0;
	int cfg_errors  = 0;
	bit hold_go     = 1'b0;

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_top failed");
		$finish;
	end

	// result receiver with random stalls and one long hold-off
	initial begin
		int  stall_left;
		bit  hold_done;
		stall_left = 0;
		hold_done  = 1'b0;
		res.ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res.ready = 1'b0;
				stall_left--;
			end else if (!quiet && !hold_done && hold_go) begin
				res.ready  = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				hold_done  = 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				res.ready  = 1'b0;
				stall_left = $urandom_range(1, 10) - 1;
			end else begin
				res.ready = 1'b1;
			end
			@(posedge clk);
			if (res.valid === 1'b1 && res.ready === 1'b1) begin
				sb.check_product(res.out_row, res.out_col, res.product_value);
			end
		end
	end

	// random element with the extremes weighted in
	function automatic logic signed [ELEM_W-1:0] rand_elem();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	function automatic bit operands_ready(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
		for (int k = 0; k < cur_len; k++)
			if (!left_set[r*MAX_INNER + k] || !right_set[k*MAX_COLS + c])
				return 1'b0;
		return 1'b1;
	endfunction

	// offer one request; starts and ends at a falling edge
	task automatic send_req(input logic [KIND_W-1:0] kind, input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic signed [ELEM_W-1:0] val);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			cmd.valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		cmd.valid         = 1'b1;
		cmd.kind          = kind;
		cmd.row_index     = row;
		cmd.col_index     = col;
		cmd.element_value = val;
		do @(posedge clk); while (cmd.ready !== 1'b1);
		sb.note_request(kind, row, col, val);
		if (kind == KIND_WRITE_LEFT)
			left_set[row*MAX_INNER + col] = 1'b1;
		else if (kind == KIND_WRITE_RIGHT)
			right_set[row*MAX_COLS + col] = 1'b1;
		if (kind != KIND_NONE)
			items_sent++;
		quiet = (items_sent >= QUIET_FROM);
		@(negedge clk);
	endtask

	// register read with compare; starts and ends at a falling edge
	task automatic read_check(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] want);
		logic [PDATA_W-1:0] got;
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = addr;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		got = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (got !== want) begin
			$error("prdata: expected %0d, actual %0d", want, got);
			cfg_errors++;
		end
	endtask

	// change inner_dim once the core has gone idle
	task automatic program_dim(input logic [DIM_W-1:0] d);
		logic [PDATA_W-1:0] word;
		cmd.valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		word = PDATA_W'(d);
		if ($urandom_range(0, 1) == 1) begin
			word = $urandom;
			word[DIM_W-1:0] = d;
		end
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = REG_INNER_DIM;
		pwdata  = word;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		sb.set_inner_dim(d);
		cur_len = (d > MAX_INNER) ? MAX_INNER : int'(d);
		read_check(REG_INNER_DIM, PDATA_W'(d));
	endtask

	// stray request: dropped kind or a write anywhere
	task automatic send_noise();
		case ($urandom_range(0, 2))
			0: send_req(KIND_NONE, ROW_W'($urandom), COL_W'($urandom), ELEM_W'($urandom));
			1: send_req(KIND_WRITE_LEFT, ROW_W'($urandom), COL_W'($urandom), rand_elem());
			default: send_req(KIND_WRITE_RIGHT, ROW_W'($urandom), COL_W'($urandom), rand_elem());
		endcase
	endtask

	// fill one left row and one right column, then ask for a few products
	task automatic run_sequence();
		logic [ROW_W-1:0] r;
		logic [COL_W-1:0] c;
		logic [ROW_W-1:0] r2;
		logic [COL_W-1:0] c2;
		r = ROW_W'($urandom);
		c = COL_W'($urandom);
		for (int k = 0; k < cur_len; k++) begin
			if (!left_set[r*MAX_INNER + k] || $urandom_range(0, 3) == 0)
				send_req(KIND_WRITE_LEFT, r, COL_W'(k), rand_elem());
			if (!right_set[k*MAX_COLS + c] || $urandom_range(0, 3) == 0)
				send_req(KIND_WRITE_RIGHT, ROW_W'(k), c, rand_elem());
			if ($urandom_range(0, 15) == 0)
				send_noise();
		end
		repeat ($urandom_range(1, 4)) begin
			r2 = ROW_W'($urandom);
			c2 = COL_W'($urandom);
			if (!operands_ready(r2, c2)) begin
				r2 = r;
				c2 = c;
			end
			send_req(KIND_COMPUTE, r2, c2, ELEM_W'($urandom));
		end
	endtask

	// main stimulus
	initial begin
		int               forced [3];
		int               phase;
		logic [DIM_W-1:0] d;
		forced = '{1, 0, 127};
		phase  = 0;
		arst_n            = 1'b0;
		cmd.valid         = 1'b0;
		cmd.kind          = KIND_WRITE_LEFT;
		cmd.row_index     = '0;
		cmd.col_index     = '0;
		cmd.element_value = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		sb = new();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset value of inner_dim, then full-length sums at the extremes
		read_check(REG_INNER_DIM, PDATA_W'(INNER_DIM_RST));
		for (int k = 0; k < MAX_INNER; k++) begin
			send_req(KIND_WRITE_LEFT, 6'd5, COL_W'(k), 16'sh8000);
			send_req(KIND_WRITE_LEFT, 6'd6, COL_W'(k), 16'sh7FFF);
			send_req(KIND_WRITE_RIGHT, ROW_W'(k), 6'd9, 16'sh8000);
		end
		send_req(KIND_COMPUTE, 6'd5, 6'd9, '0);
		send_req(KIND_COMPUTE, 6'd6, 6'd9, 16'sh7FFF);
		run_sequence();

		// directed corners with a two-long inner dimension
		program_dim(7'd2);
		send_req(KIND_WRITE_LEFT, 6'd0, 6'd0, 16'sh7FFF);
		send_req(KIND_WRITE_LEFT, 6'd0, 6'd1, 16'sh7FFF);
		send_req(KIND_WRITE_RIGHT, 6'd0, 6'd0, 16'sh7FFF);
		send_req(KIND_WRITE_RIGHT, 6'd1, 6'd0, 16'sh7FFF);
		send_req(KIND_WRITE_LEFT, 6'd63, 6'd0, 16'sh8000);
		send_req(KIND_WRITE_LEFT, 6'd63, 6'd1, 16'sh8000);
		send_req(KIND_WRITE_RIGHT, 6'd0, 6'd63, 16'sh8000);
		send_req(KIND_WRITE_RIGHT, 6'd1, 6'd63, 16'sh8000);
		// receiver holds off here so that back-to-back computes back up
		hold_go = 1'b1;
		send_req(KIND_COMPUTE, 6'd0, 6'd0, '0);
		send_req(KIND_COMPUTE, 6'd63, 6'd63, '0);
		send_req(KIND_COMPUTE, 6'd0, 6'd63, '0);
		send_req(KIND_COMPUTE, 6'd63, 6'd0, 16'shFFFF);
		// dropped kind must leave the stores alone
		send_req(KIND_NONE, 6'd63, 6'd1, 16'sh1234);
		send_req(KIND_NONE, 6'd1, 6'd63, 16'shFFFF);
		send_req(KIND_COMPUTE, 6'd63, 6'd63, '0);
		send_req(KIND_WRITE_LEFT, 6'd0, 6'd63, 16'sh5A5A);
		send_req(KIND_WRITE_RIGHT, 6'd63, 6'd0, 16'shA5A5);
		send_req(KIND_COMPUTE, 6'd0, 6'd0, '0);

		// random phases, mostly short inner dimensions
		while (items_sent < ITEM_TARGET) begin
			if (phase < 3) begin
				d = DIM_W'(forced[phase]);
			end else begin
				case ($urandom_range(0, 15))
					0: d = 7'd0;
					1: d = 7'd64;
					2: d = 7'd127;
					3: d = DIM_W'($urandom_range(65, 126));
					4: d = DIM_W'($urandom_range(9, 63));
					default: d = DIM_W'($urandom_range(1, 8));
				endcase
			end
			program_dim(d);
			repeat ((cur_len > 16) ? $urandom_range(1, 2) : $urandom_range(3, 10))
				run_sequence();
			phase++;
		end

		// drain and verdict
		cmd.valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			$error("%0d products never arrived", sb.pending());
		if (sb.errors == 0 && cfg_errors == 0 && sb.pending() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
